@@ design/stpq_pkg.sv @@
// Shared types, constants and helpers for the stable three-level priority queue.
package stpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 16;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_SERVE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    COND_NORMAL   = 2'd0,
    COND_URGENT   = 2'd1,
    COND_CRITICAL = 2'd2,
    COND_SPARE    = 2'd3
  } cond_e;

  localparam logic [1:0] PRIO_NONE     = 2'd0;
  localparam logic [1:0] PRIO_NORMAL   = 2'd1;
  localparam logic [1:0] PRIO_URGENT   = 2'd2;
  localparam logic [1:0] PRIO_CRITICAL = 2'd3;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] entry_id;
    logic [1:0]      condition_code;
  } in_item_t;

  typedef struct packed {
    logic            served_valid;
    logic [ID_W-1:0] served_id;
    logic [1:0]      served_priority;
    logic            dropped;
    logic [4:0]      occupancy;
    logic            is_empty;
    logic [ID_W-1:0] front_id;
    logic [1:0]      front_priority;
  } out_item_t;

  // request handed from the input register to the store
  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
    logic [1:0]      prio;
  } cmd_t;

  function automatic logic [1:0] level_of(logic [1:0] code);
    logic [1:0] lvl;
    unique case (code)
      COND_CRITICAL: lvl = PRIO_CRITICAL;
      COND_URGENT:   lvl = PRIO_URGENT;
      default:       lvl = PRIO_NORMAL;
    endcase
    return lvl;
  endfunction

endpackage

@@ design/stpq_store.sv @@
// Sorted slot array with parallel compare and shift, one command per cycle.
module stpq_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  stpq_pkg::cmd_t     cmd_i,
  output stpq_pkg::out_item_t result_o
);
  import stpq_pkg::*;

  logic [ID_W-1:0]  ids_q   [CAPACITY];
  logic [ID_W-1:0]  ids_d   [CAPACITY];
  logic [1:0]       prios_q [CAPACITY];
  logic [1:0]       prios_d [CAPACITY];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAPACITY-1:0] ge;
  logic             full, empty;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // slots ahead of the new entry: stored and of equal or higher priority
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge[i] = (CNT_W'(i) < count_q) && (prios_q[i] >= cmd_i.prio);
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < CAPACITY; i++) begin
      ids_d[i]   = ids_q[i];
      prios_d[i] = prios_q[i];
    end
    result_o = '0;
    if (cmd_valid_i) begin
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (full) begin
            result_o.dropped = 1'b1;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (ge[i]) begin
                ids_d[i]   = ids_q[i];
                prios_d[i] = prios_q[i];
              end else if (i == 0) begin
                ids_d[i]   = cmd_i.id;
                prios_d[i] = cmd_i.prio;
              end else if (ge[(i == 0) ? 0 : i - 1]) begin
                ids_d[i]   = cmd_i.id;
                prios_d[i] = cmd_i.prio;
              end else begin
                ids_d[i]   = ids_q[(i == 0) ? 0 : i - 1];
                prios_d[i] = prios_q[(i == 0) ? 0 : i - 1];
              end
            end
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_SERVE: begin
          if (!empty) begin
            result_o.served_valid    = 1'b1;
            result_o.served_id       = ids_q[0];
            result_o.served_priority = prios_q[0];
            // advance every slot one place towards the front
            for (int i = 0; i < CAPACITY - 1; i++) begin
              ids_d[i]   = ids_q[i+1];
              prios_d[i] = prios_q[i+1];
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    result_o.occupancy      = 5'(count_d);
    result_o.is_empty       = (count_d == '0);
    result_o.front_id       = (count_d == '0) ? '0 : ids_d[0];
    result_o.front_priority = (count_d == '0) ? PRIO_NONE : prios_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      ids_q[i]   <= ids_d[i];
      prios_q[i] <= prios_d[i];
    end
  end

endmodule

@@ design/stable_three_level_priority_queue_core.sv @@
// Top level of the stable three-level priority queue: input and result registers.
//
// Bounded stable priority queue of CAPACITY entries. An item is taken on any cycle
// with start_i high; busy_o never rises, so one item per cycle is sustained. Each
// item yields exactly one result, strobed by result_valid_o for a single cycle. The
// transfer loads the input register, and the result register is then loaded from it
// through the slot array's parallel compare and shift. Results cannot be held off;
// the receiver must take each on the cycle it is shown.
module stable_three_level_priority_queue_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  stpq_pkg::in_item_t  item_i,
  output logic                busy_o,
  output logic                result_valid_o,
  output stpq_pkg::out_item_t result_o
);
  import stpq_pkg::*;

  logic      in_valid_q;
  cmd_t      cmd_q, cmd_d;
  logic      res_valid_q;
  out_item_t res_q;
  out_item_t res_d;
  logic      accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    cmd_d.op   = item_i.op;
    cmd_d.id   = item_i.entry_id;
    cmd_d.prio = level_of(item_i.condition_code);
  end

  stpq_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_q),
    .cmd_i       (cmd_q),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= accept;
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the stable three-level priority queue core.
`timescale 1ns / 1ps

module tb;
  import stpq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  in_item_t  req;
  logic      busy;
  logic      rep_valid;
  out_item_t rep;

  // mirror of the queue contents, front at index 0
  logic [ID_W-1:0] slot_tag [CAPACITY];
  logic [1:0]      slot_level [CAPACITY];
  int              held = 0;

  out_item_t   pending_status[$];
  out_item_t   want;
  int          errors = 0;
  int unsigned cycle_count = 0;

  stable_three_level_priority_queue_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .item_i         (req),
    .busy_o         (busy),
    .result_valid_o (rep_valid),
    .result_o       (rep)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Apply one request to the mirror and return the status it should produce.
  function automatic out_item_t apply_request(in_item_t r);
    out_item_t  o;
    logic [1:0] lvl;
    int         pos;
    o = '0;
    case (r.condition_code)
      COND_CRITICAL: lvl = PRIO_CRITICAL;
      COND_URGENT:   lvl = PRIO_URGENT;
      default:       lvl = PRIO_NORMAL;
    endcase
    if (r.op == OP_INSERT) begin
      if (held == CAPACITY) begin
        o.dropped = 1'b1;
      end else begin
        // go behind every entry of equal or higher level
        pos = 0;
        while (pos < held && slot_level[pos] >= lvl) pos++;
        for (int i = held; i > pos; i--) begin
          slot_tag[i]   = slot_tag[i-1];
          slot_level[i] = slot_level[i-1];
        end
        slot_tag[pos]   = r.entry_id;
        slot_level[pos] = lvl;
        held++;
      end
    end else if (held != 0) begin
      o.served_valid    = 1'b1;
      o.served_id       = slot_tag[0];
      o.served_priority = slot_level[0];
      for (int i = 1; i < held; i++) begin
        slot_tag[i-1]   = slot_tag[i];
        slot_level[i-1] = slot_level[i];
      end
      held--;
    end
    o.occupancy = 5'(held);
    o.is_empty  = (held == 0);
    if (held != 0) begin
      o.front_id       = slot_tag[0];
      o.front_priority = slot_level[0];
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Predict on every transfer.
  always @(posedge clk) begin
    if (rst_n && start && busy === 1'b0) pending_status.push_back(apply_request(req));
  end

  always @(posedge clk) begin
    if (rst_n && rep_valid !== 1'b0) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rep);
        errors++;
      end else begin
        want = pending_status.pop_front();
        if (rep_valid !== 1'b1) begin
          $display("%0t: result strobe expected 1 actual %b", $time, rep_valid);
          errors++;
        end
        check_field("served_valid", 16'(want.served_valid), 16'(rep.served_valid));
        check_field("served_id", want.served_id, rep.served_id);
        check_field("served_priority", 16'(want.served_priority),
                    16'(rep.served_priority));
        check_field("dropped", 16'(want.dropped), 16'(rep.dropped));
        check_field("occupancy", 16'(want.occupancy), 16'(rep.occupancy));
        check_field("is_empty", 16'(want.is_empty), 16'(rep.is_empty));
        check_field("front_id", want.front_id, rep.front_id);
        check_field("front_priority", 16'(want.front_priority), 16'(rep.front_priority));
      end
    end
  end

  // Present one request and hold it until the transfer.
  task automatic send_request(op_e op, logic [ID_W-1:0] tag, logic [1:0] code);
    in_item_t r;
    r.op             = op;
    r.entry_id       = tag;
    r.condition_code = code;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start, with noise on the payload.
  task automatic idle(int n);
    logic [$bits(in_item_t)-1:0] noise;
    repeat (n) begin
      noise = $bits(in_item_t)'($urandom);
      @(negedge clk);
      start <= 1'b0;
      req   <= noise;
    end
  endtask

  task automatic wait_drained();
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic test_empty_serve();
    send_request(OP_SERVE, 16'hFFFF, COND_SPARE);
    idle(1);
  endtask

  // Every condition code, extreme tags and a re-insert of the same tag.
  task automatic test_level_order();
    send_request(OP_INSERT, 16'h0000, COND_NORMAL);
    send_request(OP_INSERT, 16'hFFFF, COND_URGENT);
    idle(2);
    send_request(OP_INSERT, 16'hA5A5, COND_CRITICAL);
    send_request(OP_INSERT, 16'h5A5A, COND_SPARE);
    send_request(OP_INSERT, 16'h0000, COND_NORMAL);
    send_request(OP_INSERT, 16'h1234, COND_URGENT);
    repeat (6) send_request(OP_SERVE, 16'h0000, COND_NORMAL);
    send_request(OP_SERVE, 16'hFFFF, COND_CRITICAL);
    idle(1);
    wait_drained();
  endtask

  // Phases biased to fill, empty or hold level; the first one is biased to fill.
  task automatic test_random_traffic();
    int sent;
    int phase_no;
    int phase_len;
    int insert_pct;
    bit steady;
    op_e op;
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase_no == 0 ? 0 : $urandom_range(0, 3))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      phase_len = (phase_no == 0) ? 40 : $urandom_range(10, 60);
      steady    = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_SERVE;
        send_request(op, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
        sent++;
        if (!steady) idle(gap_len());
      end
      // hold off now and then until every status is back
      if (phase_no % 7 == 3) begin
        idle(1);
        wait_drained();
      end
      phase_no++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    req   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_serve();
    test_level_order();
    test_random_traffic();
    idle(1);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/stpq_pkg.sv
design/stpq_store.sv
design/stable_three_level_priority_queue_core.sv
bench/tb.sv
